>>> src/ash_pkg.sv
// ----------------------------------------------------------------------------
// ash_pkg: shared constants and SHA-256 helper functions
// Round constants, initial hash values, sigma functions and input codes.
// ----------------------------------------------------------------------------
package ash_pkg;

  localparam int CHUNK_BITS_DEF = 16;
  localparam int WORD_IDX_W = 4;
  localparam int ACC_W = 16;
  localparam int NUM_ACC = 16;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  // start/busy handshake between sequencer and round engine
  typedef struct packed {
    logic start;
    logic busy;
  } ash_eng_ctl_t;

endpackage

>>> src/ash_round.sv
// ----------------------------------------------------------------------------
// ash_round: SHA-256 compression engine, one round per cycle
// Takes a 512-bit block and the chain value, returns the updated chain value.
// ----------------------------------------------------------------------------
module ash_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [511:0]         block,
  input  logic [255:0]         chain_in,
  output logic [255:0]         chain_out,
  output ash_pkg::ash_eng_ctl_t ctl
);
  import ash_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [31:0] v_r [8];
  logic [31:0] v_nxt [8];
  logic [5:0]  rnd_r;
  logic        busy_r;
  logic        fin_r;
  logic [31:0] t1, t2, w_new;

  always_comb begin
    t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + ROUND_K[rnd_r] + w_r[0];
    t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = w_r[0] + ssig0(w_r[1]) + w_r[9] + ssig1(w_r[14]);
    for (int i = 0; i < 15; i++) w_nxt[i] = w_r[i+1];
    w_nxt[15] = w_new;
    v_nxt[7] = v_r[6]; v_nxt[6] = v_r[5]; v_nxt[5] = v_r[4]; v_nxt[4] = v_r[3] + t1;
    v_nxt[3] = v_r[2]; v_nxt[2] = v_r[1]; v_nxt[1] = v_r[0]; v_nxt[0] = t1 + t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      rnd_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      rnd_r  <= '0;
      for (int i = 0; i < 16; i++) w_r[i] <= block[511-32*i -: 32];
      for (int i = 0; i < 8; i++)  v_r[i] <= chain_in[255-32*i -: 32];
    end else if (busy_r) begin
      w_r   <= w_nxt;
      v_r   <= v_nxt;
      rnd_r <= rnd_r + 6'd1;
      if (rnd_r == 6'd63) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end else if (fin_r) begin
      fin_r <= 1'b0;
      for (int i = 0; i < 8; i++) v_r[i] <= v_r[i] + chain_in[255-32*i -: 32];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) chain_out[255-32*i -: 32] = v_r[i];
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r | fin_r | start;

endmodule

>>> src/additive_sha256_set_hash.sv
// ----------------------------------------------------------------------------
// additive_sha256_set_hash: additive multiset hash over SHA-256 digests
// Hashes byte-serial messages and adds digest chunks into an accumulator.
// ----------------------------------------------------------------------------
//  channel | ports                               | direction
//  in      | in_valid/in_ready, op,msg_byte,eom  | word in
//  out     | out_valid/out_ready, index,acc,last | word out
//
// A plain byte is stored with in_ready left high; a byte that fills a 64-byte
// block runs a compression (load, 64 rounds, chain add, hand-back) before the
// next accept. A message end runs one or two padding compressions,
// then CHUNK_BITS accumulator words, one per cycle while out_ready is high.
// A clear zeroes the accumulator. Reset returns the chain value, byte count and
// accumulator to their start values at once.
// in_ready is low while a word is being worked; a stalled output holds.
module additive_sha256_set_hash #(
  parameter int CHUNK_BITS = ash_pkg::CHUNK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_op,
  input  logic [7:0]                    in_msg_byte,
  input  logic                          in_end_of_message,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ash_pkg::WORD_IDX_W-1:0] out_word_index,
  output logic [ash_pkg::ACC_W-1:0]     out_acc_word,
  output logic                          out_last_word
);
  import ash_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COMP, ST_WAIT, ST_PAD2, ST_EMIT
  } state_t;

  state_t        state_r;
  logic [511:0]  buf_r;        // block buffer, byte 0 in the top bits
  logic [255:0]  chain_r;
  logic [63:0]   cnt_r;
  logic [ACC_W-1:0] acc_r [NUM_ACC];
  logic          final_r;      // current compression finishes the digest
  logic          need2_r;      // a second padding block follows
  logic [WORD_IDX_W-1:0] idx_r;
  logic          eng_start;
  logic [255:0]  eng_out;
  ash_eng_ctl_t  eng_ctl;
  logic [255:0]  init_chain;
  logic [5:0]    pos;
  logic [511:0]  pad_buf;
  logic [511:0]  len_buf;
  logic [63:0]   bits;
  logic [CHUNK_BITS-1:0] chunk;
  logic [CHUNK_BITS-1:0] sum;

  always_comb begin
    for (int i = 0; i < 8; i++) init_chain[255-32*i -: 32] = INIT_H[i];
  end

  ash_round u_round (
    .clk(clk), .rst_n(rst_n), .start(eng_start), .block(buf_r),
    .chain_in(chain_r), .chain_out(eng_out), .ctl(eng_ctl)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_word_index = idx_r;
  assign out_last_word  = (idx_r == WORD_IDX_W'(CHUNK_BITS - 1));

  // pos: where this byte lands; count after absorbing is cnt_r+1
  assign pos  = cnt_r[5:0];
  assign bits = (cnt_r + 64'd1) << 3;

  // buffer with byte written, 0x80 after it and zeros behind
  always_comb begin
    pad_buf = buf_r;
    for (int i = 0; i < 64; i++) begin
      if (i == int'(pos)) pad_buf[511-8*i -: 8] = in_msg_byte;
      else if (i == int'(pos) + 1) pad_buf[511-8*i -: 8] = 8'h80;
      else if (i > int'(pos) + 1) pad_buf[511-8*i -: 8] = 8'h00;
    end
    len_buf = pad_buf;
    len_buf[63:0] = bits;
  end

  // digest chunk idx_r, most significant first
  always_comb begin
    chunk = chain_r[255 - CHUNK_BITS*int'(idx_r) -: CHUNK_BITS];
    sum   = acc_r[idx_r][CHUNK_BITS-1:0] + chunk;
  end
  assign out_acc_word = ACC_W'(sum);

  assign eng_start = (state_r == ST_COMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      chain_r <= init_chain;
      cnt_r   <= '0;
      idx_r   <= '0;
      final_r <= 1'b0;
      need2_r <= 1'b0;
      for (int i = 0; i < NUM_ACC; i++) acc_r[i] <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            if (in_op == OP_CLEAR) begin
              for (int i = 0; i < NUM_ACC; i++) acc_r[i] <= '0;
              chain_r <= init_chain;
              cnt_r   <= '0;
            end else begin
              cnt_r <= cnt_r + 64'd1;
              if (!in_end_of_message) begin
                buf_r[511-8*int'(pos) -: 8] <= in_msg_byte;
                if (pos == 6'd63) begin
                  final_r <= 1'b0;
                  state_r <= ST_COMP;
                end
              end else begin
                // 0x80 fits only if pos < 63; length fits only if pos < 55
                final_r <= 1'b1;
                if (pos >= 6'd55) begin
                  need2_r <= 1'b1;
                  buf_r   <= pad_buf;
                end else begin
                  need2_r <= 1'b0;
                  buf_r   <= len_buf;
                end
                state_r <= ST_COMP;
              end
            end
          end
        end
        ST_COMP: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (!eng_ctl.busy) begin
            chain_r <= eng_out;
            if (!final_r) begin
              state_r <= ST_IDLE;
            end else if (need2_r) begin
              need2_r <= 1'b0;
              state_r <= ST_PAD2;
            end else begin
              idx_r   <= '0;
              state_r <= ST_EMIT;
            end
          end
        end
        ST_PAD2: begin
          // a last byte at 63 filled the block, so 0x80 opens this one
          buf_r <= {(pos == 6'd0) ? 8'h80 : 8'h00, 440'd0, bits - 64'd8};
          state_r <= ST_COMP;
        end
        ST_EMIT: begin
          if (out_ready) begin
            acc_r[idx_r] <= ACC_W'(sum);
            idx_r <= idx_r + 1'b1;
            if (out_last_word) begin
              chain_r <= init_chain;
              cnt_r   <= '0;
              final_r <= 1'b0;
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
